// File: hw/rtl/mpfa_pkg.sv
`default_nettype none

package mpfa_pkg;

   // Default sizing of the allocator
   localparam int POOL_COUNT_DEF = 8;
   localparam int POOL_DEPTH_DEF = 256;

   // Field widths of the request and response words
   localparam int KIND_W   = 1;
   localparam int POOL_W   = 3;
   localparam int BLOCK_W  = 8;
   localparam int STATUS_W = 2;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int POOLS_W    = 4;
   localparam int BPP_W      = 9;
   localparam int DMASK_W    = 8;

   localparam logic [CSR_IDX_W-1:0] REG_POOLS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DMASK  = 2'd2;

   localparam logic [POOLS_W-1:0] POOLS_RST  = 4'd0;
   localparam logic [BPP_W-1:0]   BPP_RST    = 9'd256;
   localparam logic [DMASK_W-1:0] DMASK_RST  = 8'd0;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_GET  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_FREE = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DESTROYED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   // Control and status from the register block to the datapath
   typedef struct packed {
      logic [POOLS_W-1:0] pools_created;
      logic [DMASK_W-1:0] destroyed_mask;
      logic               rebuild;
      logic               busy;
   } csr_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/mpfa_ifs.sv
`default_nettype none

interface mpfa_req_if;
   logic                           valid;
   logic                           ready;
   logic [mpfa_pkg::KIND_W-1:0]    kind;
   logic [mpfa_pkg::POOL_W-1:0]    pool_number;
   logic [mpfa_pkg::BLOCK_W-1:0]   block_index;

   modport source (output valid, kind, pool_number, block_index, input ready);
   modport sink   (input valid, kind, pool_number, block_index, output ready);
endinterface

interface mpfa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mpfa_pkg::STATUS_W-1:0]  status;
   logic [mpfa_pkg::BLOCK_W-1:0]   granted_block;

   modport source (output valid, status, granted_block, input ready);
   modport sink   (input valid, status, granted_block, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mpfa_link_ram.sv
`default_nettype none

module mpfa_link_ram #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11,
   parameter int DW    = 9
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata_ff
);

   logic [DW-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/mpfa_csr.sv
`default_nettype none

module mpfa_csr #(
   parameter int POOL_COUNT = mpfa_pkg::POOL_COUNT_DEF,
   parameter int POOL_DEPTH = mpfa_pkg::POOL_DEPTH_DEF,
   parameter int AW         = 11,
   parameter int IW         = 8,
   parameter int LW         = 9
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [mpfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mpfa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output mpfa_pkg::csr_status_type               csr_st,
   output logic      [LW-1:0]                     block_count,
   output logic                                   sweep_we,
   output logic      [AW-1:0]                     sweep_addr,
   output logic      [LW-1:0]                     sweep_data
);

   import mpfa_pkg::*;

   localparam int            DEPTH     = POOL_COUNT * POOL_DEPTH;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [IW-1:0] LAST_IDX  = IW'(POOL_DEPTH - 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

   logic [POOLS_W-1:0] pools_ff;
   logic [BPP_W-1:0]   bpp_ff;
   logic [DMASK_W-1:0] dmask_ff;
   logic               rebuild_ff;
   logic               sweep_on_ff;
   logic [AW-1:0]      addr_ff;
   logic [IW-1:0]      idx_ff;
   logic [LW-1:0]      next_idx;

   // Register writes; a write to the pool count or block count rebuilds the lists
   always_ff @(posedge clock) begin
      if (reset) begin
         pools_ff    <= POOLS_RST;
         bpp_ff      <= BPP_RST;
         dmask_ff    <= DMASK_RST;
         rebuild_ff  <= 1'b1;
         sweep_on_ff <= 1'b1;
         addr_ff     <= '0;
         idx_ff      <= '0;
      end else begin
         rebuild_ff <= 1'b0;
         if (sweep_on_ff) begin
            addr_ff <= addr_ff + AW'(1);
            idx_ff  <= (idx_ff == LAST_IDX) ? '0 : idx_ff + IW'(1);
            if (addr_ff == LAST_ADDR) begin
               sweep_on_ff <= 1'b0;
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               REG_POOLS: begin
                  pools_ff    <= csr_wdata[POOLS_W-1:0];
                  rebuild_ff  <= 1'b1;
                  sweep_on_ff <= 1'b1;
                  addr_ff     <= '0;
                  idx_ff      <= '0;
               end
               REG_BLOCKS: begin
                  bpp_ff      <= csr_wdata[BPP_W-1:0];
                  rebuild_ff  <= 1'b1;
                  sweep_on_ff <= 1'b1;
                  addr_ff     <= '0;
                  idx_ff      <= '0;
               end
               REG_DMASK: begin
                  dmask_ff <= csr_wdata[DMASK_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Saturate the block count to the pool depth
   assign block_count = (int'(bpp_ff) > POOL_DEPTH) ? NULL_LINK : LW'(bpp_ff);

   // Sweep writes the fresh chain i -> i+1, last counted block and the rest null
   assign next_idx   = LW'(idx_ff) + LW'(1);
   assign sweep_we   = sweep_on_ff;
   assign sweep_addr = addr_ff;
   assign sweep_data = (next_idx < block_count) ? next_idx : NULL_LINK;

   assign csr_st.pools_created  = pools_ff;
   assign csr_st.destroyed_mask = dmask_ff;
   assign csr_st.rebuild        = rebuild_ff;
   assign csr_st.busy           = sweep_on_ff | rebuild_ff;

   // A rebuild always starts a sweep
   a_rebuild_sweeps: assert property (@(posedge clock) disable iff (reset)
      rebuild_ff |-> sweep_on_ff)
      else $error("rebuild without sweep");

   // The sweep ends only at the last address
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      sweep_on_ff && !csr_we && addr_ff != LAST_ADDR |=> sweep_on_ff)
      else $error("sweep ended early");

   // Address and pool index counters stay aligned
   a_idx_wrap: assert property (@(posedge clock) disable iff (reset)
      sweep_on_ff && addr_ff == LAST_ADDR |-> idx_ff == LAST_IDX)
      else $error("sweep counters out of step");

endmodule

`default_nettype wire

// File: hw/rtl/multi_pool_free_list_allocator.sv
`default_nettype none

// Multi-pool free-list block allocator.
// Requests arrive on req_ch (kind, pool_number, block_index); kind get pops the head
// block of the pool's free list, kind free pushes block_index back as the new head.
// Every request yields exactly one word on rsp_ch: status (ok, invalid pool,
// destroyed pool, empty pool) and granted_block (popped index on an ok get, else 0).
// Registers are written on csr_we/csr_index/csr_wdata: 0 pools created, 1 blocks per
// pool, 2 destroyed mask. Write them only while no request is in flight.
// An accepted request passes the input register, then the result register, before
// it is presented on rsp_ch. Throughput: one request per cycle, any mix of pools,
// while rsp_ch takes results and no sweep runs; each pool keeps its head and two
// prefetched links in flops, and the link memory is read at most once per get to
// refill the prefetch. Reset, and every write of register 0 or 1, rebuilds all
// lists as 0,1,..,count-1 with a sweep over all POOL_COUNT*POOL_DEPTH link entries
// (2048 by default) while req_ch.ready is low; csr writes are taken during the sweep.
// When rsp_ch stalls the result is held, one more request waits in the input
// register, and then req_ch.ready drops until the result is taken.
module multi_pool_free_list_allocator #(
   parameter int POOL_COUNT = mpfa_pkg::POOL_COUNT_DEF,
   parameter int POOL_DEPTH = mpfa_pkg::POOL_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   mpfa_req_if.sink                               req_ch,
   mpfa_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [mpfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mpfa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import mpfa_pkg::*;

   localparam int PW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
   localparam int IW    = $clog2(POOL_DEPTH);
   localparam int LW    = $clog2(POOL_DEPTH + 1);
   localparam int DEPTH = POOL_COUNT * POOL_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);
   localparam logic [AW-1:0] DEPTH_A   = AW'(POOL_DEPTH);

   csr_status_type csr_st;
   logic [LW-1:0]  block_count;
   logic           sweep_we;
   logic [AW-1:0]  sweep_addr;
   logic [LW-1:0]  sweep_data;

   // Input register
   logic                in_valid_ff;
   logic [KIND_W-1:0]   in_kind_ff;
   logic [POOL_W-1:0]   in_pool_ff;
   logic [BLOCK_W-1:0]  in_blk_ff;

   // Result register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [BLOCK_W-1:0]  rsp_grant_ff;

   // Per-pool head and prefetched links
   logic [LW-1:0] head_ff [POOL_COUNT];
   logic [LW-1:0] n1_ff   [POOL_COUNT];
   logic [LW-1:0] n2_ff   [POOL_COUNT];
   logic          pend_valid_ff;
   logic [PW-1:0] pend_pool_ff;

   logic                adv;
   logic [PW-1:0]       pidx;
   logic [LW-1:0]       cur_head;
   logic [LW-1:0]       cur_n1;
   logic [LW-1:0]       cur_n2;
   logic [LW-1:0]       blk_link;
   logic                blk_ok;
   logic [STATUS_W-1:0] status_in;
   logic [BLOCK_W-1:0]  grant_in;
   logic                do_pop;
   logic                do_push;
   logic                ram_re;
   logic                ram_we;
   logic [AW-1:0]       ram_raddr;
   logic [AW-1:0]       ram_waddr;
   logic [LW-1:0]       ram_wdata;
   logic [LW-1:0]       ram_rdata;
   logic [AW-1:0]       pool_base;
   logic [LW-1:0]       init_head;
   logic [LW-1:0]       init_n1;
   logic [LW-1:0]       init_n2;

   mpfa_csr #(
      .POOL_COUNT (POOL_COUNT),
      .POOL_DEPTH (POOL_DEPTH),
      .AW         (AW),
      .IW         (IW),
      .LW         (LW)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .csr_st      (csr_st),
      .block_count (block_count),
      .sweep_we    (sweep_we),
      .sweep_addr  (sweep_addr),
      .sweep_data  (sweep_data)
   );

   mpfa_link_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (LW)
   ) u_link_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .re       (ram_re),
      .raddr    (ram_raddr),
      .rdata_ff (ram_rdata)
   );

   // Handshake: advance when the result register is free or being drained
   assign adv          = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !csr_st.busy && (!in_valid_ff || adv);

   // Look up the addressed pool, taking a link that lands this cycle
   assign pidx      = PW'(in_pool_ff);
   assign cur_head  = head_ff[pidx];
   assign cur_n1    = n1_ff[pidx];
   assign cur_n2    = (pend_valid_ff && pend_pool_ff == pidx) ? ram_rdata : n2_ff[pidx];
   assign blk_link  = LW'(in_blk_ff);
   assign blk_ok    = int'(in_blk_ff) < POOL_DEPTH;
   assign pool_base = AW'(pidx) * DEPTH_A;

   // Check the request and form the result word
   always_comb begin
      status_in = ST_OK;
      grant_in  = '0;
      if (({1'b0, in_pool_ff} >= csr_st.pools_created) || (int'(in_pool_ff) >= POOL_COUNT)) begin
         status_in = ST_INVALID;
      end else if (csr_st.destroyed_mask[in_pool_ff]) begin
         status_in = ST_DESTROYED;
      end else if (in_kind_ff == KIND_GET) begin
         if (cur_head == NULL_LINK) begin
            status_in = ST_EMPTY;
         end else begin
            grant_in = BLOCK_W'(cur_head);
         end
      end
   end

   assign do_pop  = adv && (status_in == ST_OK) && (in_kind_ff == KIND_GET);
   assign do_push = adv && (status_in == ST_OK) && (in_kind_ff == KIND_FREE) && blk_ok;

   // Memory: refill the prefetch on a get, link the freed block on a free
   assign ram_re    = do_pop && (cur_n2 != NULL_LINK);
   assign ram_raddr = pool_base + AW'(cur_n2[IW-1:0]);
   assign ram_we    = sweep_we || do_push;
   assign ram_waddr = sweep_we ? sweep_addr : pool_base + AW'(blk_link[IW-1:0]);
   assign ram_wdata = sweep_we ? sweep_data : cur_head;

   // Fresh list heads after a rebuild
   assign init_head = (block_count > LW'(0)) ? LW'(0) : NULL_LINK;
   assign init_n1   = (block_count > LW'(1)) ? LW'(1) : NULL_LINK;
   assign init_n2   = (block_count > LW'(2)) ? LW'(2) : NULL_LINK;

   // Pool state: land pending links, then pop or push
   always_ff @(posedge clock) begin
      if (reset || csr_st.rebuild) begin
         for (int p = 0; p < POOL_COUNT; p++) begin
            head_ff[p] <= init_head;
            n1_ff[p]   <= init_n1;
            n2_ff[p]   <= init_n2;
         end
         pend_valid_ff <= 1'b0;
         pend_pool_ff  <= '0;
      end else begin
         // land a pending link unless this word rewrites the same pool
         if (pend_valid_ff && !((do_pop || do_push) && (pend_pool_ff == pidx))) begin
            n2_ff[pend_pool_ff] <= ram_rdata;
         end
         pend_valid_ff <= ram_re;
         pend_pool_ff  <= pidx;
         if (do_pop) begin
            head_ff[pidx] <= cur_n1;
            n1_ff[pidx]   <= cur_n2;
            n2_ff[pidx]   <= NULL_LINK;
         end else if (do_push) begin
            head_ff[pidx] <= blk_link;
            n1_ff[pidx]   <= cur_head;
            n2_ff[pidx]   <= (blk_link == cur_head) ? cur_head : cur_n1;
         end
      end
   end

   // Input register: hold until the word advances
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (adv) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_kind_ff <= req_ch.kind;
         in_pool_ff <= req_ch.pool_number;
         in_blk_ff  <= req_ch.block_index;
      end
   end

   // Result register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_status_ff <= status_in;
         rsp_grant_ff  <= grant_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.granted_block = rsp_grant_ff;

   // An error word never carries a block
   a_err_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_grant_ff == '0)
      else $error("granted block on error status");

   // No request enters while the lists are being rebuilt
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |-> !csr_st.busy)
      else $error("request accepted during rebuild");

   // A new result follows an advancing request
   a_rsp_from_adv: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(adv))
      else $error("result without request");

   // A pending link read only follows a get
   a_pend_after_pop: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> $past(do_pop))
      else $error("link read without get");

endmodule

`default_nettype wire

// File: dv/multi_pool_free_list_allocator_checker.sv
module multi_pool_free_list_allocator_checker #(
   parameter int POOL_COUNT = mpfa_pkg::POOL_COUNT_DEF,
   parameter int POOL_DEPTH = mpfa_pkg::POOL_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   mpfa_req_if                             req_ch,
   mpfa_rsp_if                             rsp_ch,
   input  logic                            csr_we,
   input  logic [mpfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mpfa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import mpfa_pkg::*;

   // A link or head one wider than a block index, so the null code fits
   localparam int                LINK_W    = $clog2(POOL_DEPTH) + 1;
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_DEPTH);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BLOCK_W-1:0]  granted;
   } grant_word_type;

   logic [POOLS_W-1:0] pools_created;
   logic [BPP_W-1:0]   blocks_per_pool;
   logic [DMASK_W-1:0] destroyed_mask;

   logic [LINK_W-1:0]  list_head [POOL_COUNT];
   logic [LINK_W-1:0]  next_link [POOL_COUNT][POOL_DEPTH];

   grant_word_type     grants_due [$];

   // Rebuild every pool as 0,1,..,count-1 followed by null
   function automatic void chain_all_pools();
      int count;
      count = (int'(blocks_per_pool) > POOL_DEPTH) ? POOL_DEPTH : int'(blocks_per_pool);
      for (int p = 0; p < POOL_COUNT; p++) begin
         for (int i = 0; i < POOL_DEPTH; i++) begin
            next_link[p][i] = (i + 1 < count) ? LINK_W'(i + 1) : LINK_NULL;
         end
         list_head[p] = (count == 0) ? LINK_NULL : '0;
      end
   endfunction

   // Pop or push one pool list and return the word the block should answer with
   function automatic grant_word_type serve_request(input logic [KIND_W-1:0]  kind,
                                                    input logic [POOL_W-1:0]  pool,
                                                    input logic [BLOCK_W-1:0] blk);
      grant_word_type    word;
      logic [LINK_W-1:0] head;
      word.status  = ST_OK;
      word.granted = '0;
      if (int'(pool) >= int'(pools_created) || int'(pool) >= POOL_COUNT) begin
         word.status = ST_INVALID;
      end else if (destroyed_mask[pool]) begin
         word.status = ST_DESTROYED;
      end else if (kind == KIND_GET) begin
         head = list_head[pool];
         if (int'(head) >= POOL_DEPTH) begin
            word.status = ST_EMPTY;
         end else begin
            list_head[pool] = next_link[pool][head];
            word.granted    = BLOCK_W'(head);
         end
      end else if (int'(blk) < POOL_DEPTH) begin
         // out-of-range blocks are dropped silently
         next_link[pool][blk] = list_head[pool];
         list_head[pool]      = LINK_W'(blk);
      end
      return word;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t allocator mismatch: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      grant_word_type due;
      if (reset) begin
         pools_created   = POOLS_RST;
         blocks_per_pool = BPP_RST;
         destroyed_mask  = DMASK_RST;
         chain_all_pools();
         grants_due.delete();
      end else begin
         // apply register writes; pool count and block count rebuild the lists
         if (csr_we) begin
            case (csr_index)
               REG_POOLS: begin
                  pools_created = csr_wdata[POOLS_W-1:0];
                  chain_all_pools();
               end
               REG_BLOCKS: begin
                  blocks_per_pool = csr_wdata[BPP_W-1:0];
                  chain_all_pools();
               end
               REG_DMASK: begin
                  destroyed_mask = csr_wdata[DMASK_W-1:0];
               end
               default: begin
               end
            endcase
         end

         // compare the word leaving the block against the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (grants_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word status %0d block %0d",
                                         rsp_ch.status, rsp_ch.granted_block));
            end else begin
               due = grants_due.pop_front();
               if (rsp_ch.status !== due.status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_ch.status, due.status));
               if (rsp_ch.granted_block !== due.granted)
                  report_mismatch($sformatf("granted block %0d, predicted %0d",
                                            rsp_ch.granted_block, due.granted));
            end
         end

         // predict the answer to each accepted request
         if (req_ch.valid && req_ch.ready) begin
            grants_due.push_back(serve_request(req_ch.kind, req_ch.pool_number,
                                               req_ch.block_index));
         end
      end
      words_pending <= grants_due.size();
   end

endmodule

// File: dv/multi_pool_free_list_allocator_tb.sv
module multi_pool_free_list_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mpfa_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   localparam int LIMIT_CYCLES  = 500000;
   localparam int IDLE_PCT      = 15;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_AT       = 150;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_FROM    = 300;
   localparam int QUIET_TO      = 400;
   localparam int RAND_PHASES   = 6;
   localparam int PHASE_WORDS   = 85;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                    fail_count;
   int                    words_pending;
   int                    words_back  = 0;
   int                    cycle_count = 0;
   logic                  quiet;

   mpfa_req_if req_ch ();
   mpfa_rsp_if rsp_ch ();

   multi_pool_free_list_allocator #(
      .POOL_COUNT (POOL_COUNT_DEF),
      .POOL_DEPTH (POOL_DEPTH_DEF)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   multi_pool_free_list_allocator_checker #(
      .POOL_COUNT (POOL_COUNT_DEF),
      .POOL_DEPTH (POOL_DEPTH_DEF)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   always #5 clock = ~clock;

   // no idling on either side inside this window of returned words
   assign quiet = (words_back >= QUIET_FROM) && (words_back < QUIET_TO);

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side: random stalls plus one long hold-off to back the block up
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            if (rsp_ch.valid && rsp_ch.ready) words_back <= words_back + 1;
            if (hold_left > 0) begin
               hold_left = hold_left - 1;
               rsp_ch.ready <= 1'b0;
            end else if (!hold_done && words_back == HOLD_AT) begin
               hold_done = 1'b1;
               hold_left = HOLD_CYCLES;
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
         end
      end
   end

   // Offer one request word, with random idle cycles ahead of it
   task automatic send_word(input logic [KIND_W-1:0]  kind,
                            input logic [POOL_W-1:0]  pool,
                            input logic [BLOCK_W-1:0] blk);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.pool_number <= pool;
      req_ch.block_index <= blk;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
   endtask

   // Drop valid and wait until every predicted word has come back
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0]  idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Random mix of gets and frees, mostly on live pools and counted blocks
   task automatic run_random_phase(input int words, input int pools, input int blocks);
      int                 live_pools;
      int                 top_block;
      logic [KIND_W-1:0]  kind;
      logic [POOL_W-1:0]  pool;
      logic [BLOCK_W-1:0] blk;
      live_pools = (pools > POOL_COUNT_DEF) ? POOL_COUNT_DEF : pools;
      top_block  = (blocks > POOL_DEPTH_DEF) ? POOL_DEPTH_DEF - 1 :
                   (blocks == 0) ? 0 : blocks - 1;
      for (int n = 0; n < words; n++) begin
         kind = ($urandom_range(0, 99) < 55) ? KIND_GET : KIND_FREE;
         if (live_pools > 0 && $urandom_range(0, 99) < 85)
            pool = POOL_W'($urandom_range(0, live_pools - 1));
         else
            pool = POOL_W'($urandom);
         if ($urandom_range(0, 99) < 80)
            blk = BLOCK_W'($urandom_range(0, top_block));
         else
            blk = BLOCK_W'($urandom);
         send_word(kind, pool, blk);
      end
      settle();
   endtask

   initial begin
      int                 pools;
      int                 blocks;
      logic [DMASK_W-1:0] dmask;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_GET;
      req_ch.pool_number <= '0;
      req_ch.block_index <= '0;
      csr_we             <= 1'b0;
      csr_index          <= REG_POOLS;
      csr_wdata          <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // out of reset no pool exists
      send_word(KIND_GET, 3'd0, 8'd0);
      send_word(KIND_FREE, 3'd7, 8'd255);
      settle();

      // pool count above the limit, three blocks each, pool 5 destroyed
      write_reg(REG_POOLS, CSR_DATA_W'(15));
      write_reg(REG_BLOCKS, CSR_DATA_W'(3));
      write_reg(REG_DMASK, CSR_DATA_W'(8'h20));
      write_reg(REG_UNUSED, CSR_DATA_W'(9'h1FF));
      // drain pool 0 until it runs empty
      repeat (4) send_word(KIND_GET, 3'd0, 8'd0);
      // push back the top block index and a block beyond the count
      send_word(KIND_FREE, 3'd0, 8'd255);
      send_word(KIND_GET, 3'd0, 8'd0);
      send_word(KIND_FREE, 3'd0, 8'd7);
      send_word(KIND_GET, 3'd0, 8'd0);
      // destroyed pool rejects both kinds
      send_word(KIND_FREE, 3'd5, 8'd1);
      send_word(KIND_GET, 3'd5, 8'd0);
      send_word(KIND_GET, 3'd7, 8'd0);
      // double free of the head loops the list onto itself
      send_word(KIND_FREE, 3'd3, 8'd0);
      send_word(KIND_GET, 3'd3, 8'd0);
      send_word(KIND_GET, 3'd3, 8'd0);
      settle();

      // revive pool 5 with its list untouched
      write_reg(REG_DMASK, '0);
      send_word(KIND_GET, 3'd5, 8'd0);
      settle();

      // shrink to five pools
      write_reg(REG_POOLS, CSR_DATA_W'(5));
      send_word(KIND_GET, 3'd5, 8'd0);
      send_word(KIND_FREE, 3'd6, 8'h55);
      settle();

      // zero blocks: empty lists that frees can still fill
      write_reg(REG_BLOCKS, '0);
      send_word(KIND_GET, 3'd1, 8'd0);
      send_word(KIND_FREE, 3'd1, 8'hAA);
      send_word(KIND_GET, 3'd1, 8'd0);
      send_word(KIND_GET, 3'd1, 8'd0);
      settle();

      // oversized block count, every pool destroyed
      write_reg(REG_BLOCKS, CSR_DATA_W'(511));
      write_reg(REG_DMASK, CSR_DATA_W'(8'hFF));
      send_word(KIND_GET, 3'd2, 8'd0);
      settle();

      // random phases over a spread of settings
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0: begin
               pools  = 8;
               blocks = 4;
               dmask  = '0;
            end
            1: begin
               pools  = 15;
               blocks = 256;
               dmask  = DMASK_W'($urandom) & DMASK_W'($urandom);
            end
            2: begin
               pools  = 3;
               blocks = 1;
               dmask  = '0;
            end
            default: begin
               pools = ($urandom_range(0, 99) < 70) ? 8 : $urandom_range(0, 15);
               case ($urandom_range(0, 9))
                  0:       blocks = 0;
                  1:       blocks = 511;
                  2:       blocks = 256;
                  default: blocks = $urandom_range(1, 16);
               endcase
               dmask = DMASK_W'($urandom) & DMASK_W'($urandom);
            end
         endcase
         write_reg(REG_POOLS, CSR_DATA_W'(pools));
         write_reg(REG_BLOCKS, CSR_DATA_W'(blocks));
         write_reg(REG_DMASK, CSR_DATA_W'(dmask));
         run_random_phase(PHASE_WORDS, pools, blocks);
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
